// ===== hdl/imu_complementary_tilt_filter_unit_assert.svh =====
// Assertion macros for the tilt filter RTL.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_UNIT_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ICTF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ICTF_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICTF_ASSERT(lbl, clk, rstn, prop, msg)
`define ICTF_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/ictf_pkg.sv =====
package ictf_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TABLE_FRAC          = 20;
  localparam int SQ_PRESCALE         = 14;

  localparam logic [4:0] DIV_LAST = 5'd27;
  localparam logic [4:0] SQ_LAST  = 5'd29;
  localparam logic [4:0] CD_LAST  = 5'd19;

  localparam logic [2:0] CFG_GYRO_GAIN     = 3'd0;
  localparam logic [2:0] CFG_YAW_GAIN      = 3'd1;
  localparam logic [2:0] CFG_ACCEL_WEIGHT  = 3'd2;
  localparam logic [2:0] CFG_SMOOTH_WEIGHT = 3'd3;
  localparam logic [2:0] CFG_CAL_SAMPLES   = 3'd4;

  localparam logic [23:0] GYRO_GAIN_RST     = 24'd262423;
  localparam logic [23:0] YAW_GAIN_RST      = 24'd1172078;
  localparam logic [24:0] ACCEL_WEIGHT_RST  = 25'd6711;
  localparam logic [16:0] SMOOTH_WEIGHT_RST = 17'd6554;
  localparam logic [11:0] CAL_SAMPLES_RST   = 12'd2000;

  localparam logic [3:0] MI_GYRO_P   = 4'd0;
  localparam logic [3:0] MI_GYRO_R   = 4'd1;
  localparam logic [3:0] MI_YAW      = 4'd2;
  localparam logic [3:0] MI_CPL_P    = 4'd3;
  localparam logic [3:0] MI_CPL_R    = 4'd4;
  localparam logic [3:0] MI_SQ_P0    = 4'd5;
  localparam logic [3:0] MI_SQ_P1    = 4'd6;
  localparam logic [3:0] MI_SQ_R0    = 4'd7;
  localparam logic [3:0] MI_SQ_R1    = 4'd8;
  localparam logic [3:0] MI_BLEND_P  = 4'd9;
  localparam logic [3:0] MI_BLEND_R  = 4'd10;
  localparam logic [3:0] MI_SMOOTH_P = 4'd11;
  localparam logic [3:0] MI_SMOOTH_R = 4'd12;

  localparam logic [3:0] AXIS_LAST = 4'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_DIV_INIT, ST_DIV_STEP, ST_DIV_END, ST_CORR,
    ST_M_LD, ST_M_WT, ST_M_US, ST_SQ_INIT, ST_SQ_STEP, ST_CD_INIT,
    ST_CD_STEP, ST_CD_END, ST_SEED, ST_EMIT_CAL, ST_EMIT_RUN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_CAL_ACC, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
    OP_CORR, OP_M_LD, OP_M_US, OP_SQ_INIT, OP_SQ_STEP, OP_CD_INIT,
    OP_CD_STEP, OP_CD_END, OP_SEED, OP_EMIT_CAL, OP_EMIT_RUN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] mi;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic calibrated;
    logic cal_done;
    logic seeded;
  } status_t;

  function automatic logic signed [31:0] cordic_atan(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
    logic signed [63:0] r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (64'sd1 <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ictf_ctrl.sv =====
`include "imu_complementary_tilt_filter_unit_assert.svh"

module ictf_ctrl
  import ictf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [3:0] mi_r, mi_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign emit_ok = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mi_r        <= mi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mi_nxt    = mi_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_START;
      end
      ST_START: begin
        mi_nxt = '0;
        if (status.calibrated) state_nxt = ST_CORR;
        else if (status.cal_done) state_nxt = ST_DIV_INIT;
        else state_nxt = ST_EMIT_CAL;
      end
      ST_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        if (mi_r == AXIS_LAST) begin
          state_nxt = ST_EMIT_CAL;
        end else begin
          mi_nxt    = mi_r + 4'd1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_CORR: begin
        mi_nxt    = MI_GYRO_P;
        state_nxt = ST_M_LD;
      end
      ST_M_LD: state_nxt = ST_M_WT;
      ST_M_WT: state_nxt = ST_M_US;
      ST_M_US: begin
        if (mi_r == MI_SQ_P1 || mi_r == MI_SQ_R1) begin
          state_nxt = ST_SQ_INIT;
        end else if (mi_r == MI_SMOOTH_R) begin
          state_nxt = ST_EMIT_RUN;
        end else begin
          mi_nxt    = mi_r + 4'd1;
          state_nxt = ST_M_LD;
        end
      end
      ST_SQ_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQ_STEP;
      end
      ST_SQ_STEP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == SQ_LAST) state_nxt = ST_CD_INIT;
      end
      ST_CD_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_CD_STEP;
      end
      ST_CD_STEP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CD_LAST) state_nxt = ST_CD_END;
      end
      ST_CD_END: begin
        if (mi_r == MI_SQ_P1) begin
          mi_nxt    = MI_SQ_R0;
          state_nxt = ST_M_LD;
        end else if (status.seeded) begin
          mi_nxt    = MI_BLEND_P;
          state_nxt = ST_M_LD;
        end else begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        mi_nxt    = MI_SMOOTH_P;
        state_nxt = ST_M_LD;
      end
      ST_EMIT_CAL, ST_EMIT_RUN: begin
        if (emit_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NOP;
    cmd.mi        = mi_r;
    cmd.idx       = cnt_r;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LATCH;
      end
      ST_START: begin
        if (!status.calibrated) cmd.op = OP_CAL_ACC;
      end
      ST_DIV_INIT: cmd.op = OP_DIV_INIT;
      ST_DIV_STEP: cmd.op = OP_DIV_STEP;
      ST_DIV_END:  cmd.op = OP_DIV_END;
      ST_CORR:     cmd.op = OP_CORR;
      ST_M_LD:     cmd.op = OP_M_LD;
      ST_M_US:     cmd.op = OP_M_US;
      ST_SQ_INIT:  cmd.op = OP_SQ_INIT;
      ST_SQ_STEP:  cmd.op = OP_SQ_STEP;
      ST_CD_INIT:  cmd.op = OP_CD_INIT;
      ST_CD_STEP:  cmd.op = OP_CD_STEP;
      ST_CD_END:   cmd.op = OP_CD_END;
      ST_SEED:     cmd.op = OP_SEED;
      ST_EMIT_CAL: begin
        if (emit_ok) begin
          cmd.op        = OP_EMIT_CAL;
          out_valid_nxt = 1'b1;
        end
      end
      ST_EMIT_RUN: begin
        if (emit_ok) begin
          cmd.op        = OP_EMIT_RUN;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  assign out_tvalid = out_valid_r;

  `ICTF_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset did not idle the controller")
  `ICTF_ASSERT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready |=> state_r == ST_START, "accepted beat did not start work")
  `ICTF_ASSERT(a_emit_sets_valid, clk, rst_n, (cmd.op == OP_EMIT_RUN || cmd.op == OP_EMIT_CAL) |=> out_valid_r, "emitted result not presented")
  `ICTF_ASSERT(a_mi_range, clk, rst_n, mi_r <= MI_SMOOTH_R, "multiply index out of range")

endmodule

// ===== hdl/ictf_dp.sv =====
module ictf_dp
  import ictf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [95:0]        in_tdata,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_wdata,
  output logic signed [31:0] out_pitch,
  output logic signed [31:0] out_roll,
  output logic               out_cal,
  output logic               out_degen
);

  localparam int GYRO_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int TILT_SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;

  logic [23:0] gg_r, yg_r;
  logic [24:0] aw_r;
  logic [16:0] sw_r;
  logic [11:0] cal_r;

  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [15:0] raw_r [3];
  logic signed [16:0] rc_r [3];

  logic signed [27:0] osum_r [3];
  logic signed [15:0] roff_r [3];
  logic [11:0]        count_r;
  logic               calib_r, seeded_r;

  logic signed [31:0] pitch_r, roll_r, pf_r, rf_r, pacc_r, racc_r;
  logic signed [25:0] s_r;
  logic [31:0]        sq_r;

  logic signed [33:0] mul_a_r;
  logic signed [25:0] mul_b_r;
  logic signed [59:0] prod_r;

  logic [27:0] dq_r;
  logic [12:0] rem_r;
  logic        neg_r;

  logic [59:0] n_r, res_r, bit_r;
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;

  logic signed [31:0] op_pitch_r, op_roll_r;
  logic               op_cal_r, op_degen_r;

  logic [11:0]        need;
  logic               degen;
  logic [24:0]        aw_eff;
  logic [16:0]        sw_eff;
  logic signed [63:0] p64, tilt;
  logic [12:0]        dtrial;
  logic [59:0]        sqtrial;
  logic signed [33:0] cdx, cdy;
  logic signed [27:0] osel;

  assign need    = (cal_r == 12'd0) ? 12'd1 : cal_r;
  assign degen   = (ax_r == 16'sd0) && (ay_r == 16'sd0) && (az_r == 16'sd0);
  assign aw_eff  = (aw_r > 25'd16777216) ? 25'd16777216 : aw_r;
  assign sw_eff  = (sw_r > 17'd65536) ? 17'd65536 : sw_r;
  assign p64     = 64'(prod_r);
  assign tilt    = rshr(64'(z_r), TILT_SHIFT);
  assign dtrial  = {rem_r[11:0], dq_r[27]};
  assign sqtrial = res_r + bit_r;
  assign cdx     = y_r >>> cmd.idx;
  assign cdy     = x_r >>> cmd.idx;
  assign osel    = osum_r[cmd.mi[1:0]];

  assign status.calibrated = calib_r;
  assign status.cal_done   = ({1'b0, count_r} + 13'd1) >= {1'b0, need};
  assign status.seeded     = seeded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gg_r  <= GYRO_GAIN_RST;
      yg_r  <= YAW_GAIN_RST;
      aw_r  <= ACCEL_WEIGHT_RST;
      sw_r  <= SMOOTH_WEIGHT_RST;
      cal_r <= CAL_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO_GAIN:     gg_r  <= cfg_wdata[23:0];
        CFG_YAW_GAIN:      yg_r  <= cfg_wdata[23:0];
        CFG_ACCEL_WEIGHT:  aw_r  <= cfg_wdata;
        CFG_SMOOTH_WEIGHT: sw_r  <= cfg_wdata[16:0];
        CFG_CAL_SAMPLES:   cal_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        osum_r[k] <= '0;
        roff_r[k] <= '0;
      end
      count_r  <= '0;
      calib_r  <= 1'b0;
      seeded_r <= 1'b0;
      pitch_r  <= '0;
      roll_r   <= '0;
      pf_r     <= '0;
      rf_r     <= '0;
    end else begin
      case (cmd.op)
        OP_CAL_ACC: begin
          for (int k = 0; k < 3; k++) osum_r[k] <= osum_r[k] + 28'(raw_r[k]);
          count_r <= count_r + 12'd1;
        end
        OP_DIV_END: begin
          roff_r[cmd.mi[1:0]] <= neg_r ? 16'(-$signed({1'b0, dq_r[16:0]}))
                                       : 16'(dq_r[16:0]);
          if (cmd.mi == AXIS_LAST) calib_r <= 1'b1;
        end
        OP_M_US: begin
          case (cmd.mi)
            MI_GYRO_P:   pitch_r <= sat32(64'(pitch_r) + rshr(p64, GYRO_SHIFT));
            MI_GYRO_R:   roll_r  <= sat32(64'(roll_r) + rshr(p64, GYRO_SHIFT));
            MI_CPL_P:    pitch_r <= sat32(64'(pitch_r) + rshr(p64, 24));
            MI_CPL_R:    roll_r  <= sat32(64'(roll_r) - rshr(p64, 24));
            MI_BLEND_P:  pitch_r <= sat32(64'(pitch_r) + rshr(p64, 24));
            MI_BLEND_R:  roll_r  <= sat32(64'(roll_r) + rshr(p64, 24));
            MI_SMOOTH_P: pf_r    <= sat32(64'(pf_r) + rshr(p64, 16));
            MI_SMOOTH_R: rf_r    <= sat32(64'(rf_r) + rshr(p64, 16));
            default: ;
          endcase
        end
        OP_SEED: begin
          pitch_r  <= pacc_r;
          roll_r   <= racc_r;
          seeded_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        ax_r     <= in_tdata[15:0];
        ay_r     <= in_tdata[31:16];
        az_r     <= in_tdata[47:32];
        raw_r[0] <= in_tdata[63:48];
        raw_r[1] <= in_tdata[79:64];
        raw_r[2] <= in_tdata[95:80];
      end
      OP_CORR: begin
        for (int k = 0; k < 3; k++) rc_r[k] <= 17'(raw_r[k]) - 17'(roff_r[k]);
      end
      OP_DIV_INIT: begin
        neg_r <= osel[27];
        dq_r  <= osel[27] ? 28'(-osel) : 28'(osel);
        rem_r <= '0;
      end
      OP_DIV_STEP: begin
        if (dtrial >= {1'b0, count_r}) begin
          rem_r <= dtrial - {1'b0, count_r};
          dq_r  <= {dq_r[26:0], 1'b1};
        end else begin
          rem_r <= dtrial;
          dq_r  <= {dq_r[26:0], 1'b0};
        end
      end
      OP_M_LD: begin
        case (cmd.mi)
          MI_GYRO_P:   begin mul_a_r <= 34'(rc_r[0]); mul_b_r <= $signed({2'b0, gg_r}); end
          MI_GYRO_R:   begin mul_a_r <= 34'(rc_r[1]); mul_b_r <= $signed({2'b0, gg_r}); end
          MI_YAW:      begin mul_a_r <= 34'(rc_r[2]); mul_b_r <= $signed({2'b0, yg_r}); end
          MI_CPL_P:    begin mul_a_r <= 34'(roll_r);  mul_b_r <= s_r; end
          MI_CPL_R:    begin mul_a_r <= 34'(pitch_r); mul_b_r <= s_r; end
          MI_SQ_P0:    begin mul_a_r <= 34'(ax_r);    mul_b_r <= 26'(ax_r); end
          MI_SQ_P1:    begin mul_a_r <= 34'(az_r);    mul_b_r <= 26'(az_r); end
          MI_SQ_R0:    begin mul_a_r <= 34'(ay_r);    mul_b_r <= 26'(ay_r); end
          MI_SQ_R1:    begin mul_a_r <= 34'(az_r);    mul_b_r <= 26'(az_r); end
          MI_BLEND_P:  begin
            mul_a_r <= 34'(pacc_r) - 34'(pitch_r);
            mul_b_r <= $signed({1'b0, aw_eff});
          end
          MI_BLEND_R:  begin
            mul_a_r <= 34'(racc_r) - 34'(roll_r);
            mul_b_r <= $signed({1'b0, aw_eff});
          end
          MI_SMOOTH_P: begin
            mul_a_r <= 34'(pitch_r) - 34'(pf_r);
            mul_b_r <= $signed({9'b0, sw_eff});
          end
          MI_SMOOTH_R: begin
            mul_a_r <= 34'(roll_r) - 34'(rf_r);
            mul_b_r <= $signed({9'b0, sw_eff});
          end
          default:     begin mul_a_r <= '0; mul_b_r <= '0; end
        endcase
      end
      OP_M_US: begin
        case (cmd.mi)
          MI_YAW:             s_r  <= 26'(rshr(p64, 16));
          MI_SQ_P0, MI_SQ_R0: sq_r <= prod_r[31:0];
          MI_SQ_P1, MI_SQ_R1: sq_r <= sq_r + prod_r[31:0];
          default: ;
        endcase
      end
      OP_SQ_INIT: begin
        n_r   <= {sq_r, 28'b0};
        res_r <= '0;
        bit_r <= 60'd1 << 58;
      end
      OP_SQ_STEP: begin
        if (n_r >= sqtrial) begin
          n_r   <= n_r - sqtrial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_CD_INIT: begin
        x_r <= $signed(res_r[33:0]);
        y_r <= (cmd.mi == MI_SQ_P1) ? (34'(ay_r) <<< SQ_PRESCALE)
                                    : (34'(ax_r) <<< SQ_PRESCALE);
        z_r <= '0;
      end
      OP_CD_STEP: begin
        if (!y_r[33]) begin
          x_r <= x_r + cdx;
          y_r <= y_r - cdy;
          z_r <= z_r + cordic_atan(cmd.idx);
        end else begin
          x_r <= x_r - cdx;
          y_r <= y_r + cdy;
          z_r <= z_r - cordic_atan(cmd.idx);
        end
      end
      OP_CD_END: begin
        if (cmd.mi == MI_SQ_P1) pacc_r <= degen ? 32'sd0 : 32'(tilt);
        else racc_r <= degen ? 32'sd0 : -32'(tilt);
      end
      OP_EMIT_CAL: begin
        op_pitch_r <= '0;
        op_roll_r  <= '0;
        op_cal_r   <= 1'b1;
        op_degen_r <= 1'b0;
      end
      OP_EMIT_RUN: begin
        op_pitch_r <= pf_r;
        op_roll_r  <= rf_r;
        op_cal_r   <= 1'b0;
        op_degen_r <= degen;
      end
      default: ;
    endcase
  end

  assign out_pitch = op_pitch_r;
  assign out_roll  = op_roll_r;
  assign out_cal   = op_cal_r;
  assign out_degen = op_degen_r;

endmodule

// ===== hdl/imu_complementary_tilt_filter_unit.sv =====
// Six-axis complementary tilt filter.
// in_*: one beat per sensor sample; in_tdata holds accel x/y/z then gyro x/y/z.
// out_*: one beat per input beat; out_tdata holds smoothed pitch and roll in
// signed Q(ANGLE_FRAC_BITS) degrees, out_tuser the calibrating and
// accelerometer-degenerate flags.
// cfg_*: single-cycle register writes, to be issued while no sample is in flight.
// The first cal_samples beats build gyro offsets and return zero angles with
// calibrating set; the beat that completes calibration also runs the three
// 28-step offset divisions before its result is presented.
// A tracking beat runs 13 products through the shared multiplier (11 on the
// first beat after calibration, which seeds the angles instead of blending),
// and each of the two tilt angles takes a 30-step square root and a 20-step
// CORDIC. One sample is processed at a time; the next beat can be accepted in
// the same cycle that out_tvalid rises.
// in_tready is high only while idle. A finished beat waits in the output
// register; a stalled receiver holds the next result until that one is taken.
// Reset restores the register defaults and clears offsets, angles and flags.
module imu_complementary_tilt_filter_unit
  import ictf_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // pitch_smoothed, roll_smoothed
  output logic [1:0]  out_tuser,  // calibrating, accel_degenerate
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_wdata
);

  cmd_t               cmd;
  status_t            status;
  logic signed [31:0] pitch_o, roll_o;
  logic               cal_o, degen_o;

  ictf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ictf_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_pitch (pitch_o),
    .out_roll  (roll_o),
    .out_cal   (cal_o),
    .out_degen (degen_o)
  );

  assign out_tdata = {roll_o, pitch_o};
  assign out_tuser = {degen_o, cal_o};

endmodule

// ===== verif/tb_imu_complementary_tilt_filter_unit.sv =====
module tb_imu_complementary_tilt_filter_unit
  import ictf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 240;
  localparam int QUIET_ITEMS = 150;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } sample_t;

  typedef struct {
    logic signed [31:0] pitch, roll;
    logic calibrating, degenerate;
  } tilt_t;

  typedef struct {
    sample_t smp;
    bit      typed;
    bit      cut_cal;
    tilt_t   res;
  } row_t;

  localparam longint ATAN_Q20[20] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_GYRO_GAIN;
  logic [24:0] cfg_wdata = '0;

  imu_complementary_tilt_filter_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // filter state mirror
  longint unsigned gyro_gain, yaw_gain, accel_weight, smooth_weight, cal_target;
  int              rate_sum[3];
  int              rate_bias[3];
  int              cal_count;
  bit              cal_done, seeded;
  logic signed [31:0] pitch_est, roll_est, pitch_out, roll_out;

  tilt_t tilt_pending[$];
  int    errors = 0;
  bit    quiet = 1'b0;
  int    stall_left = 0;

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint tilt_angle(longint a, longint b, longint c);
    longint unsigned mag2;
    longint x, y, z, dx, dy;
    mag2 = b * b + c * c;
    x = longint'(int_sqrt(mag2 << 28));
    y = a <<< 14;
    z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q20[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q20[i];
      end
    end
    return round_shift(z, 20 - FRAC);
  endfunction

  function automatic tilt_t predict_tilt(sample_t s);
    tilt_t  r;
    longint g[3];
    longint sine, pacc, racc, aw, sw;
    int     need;
    g[0] = s.gx; g[1] = s.gy; g[2] = s.gz;
    r = '{pitch: 0, roll: 0, calibrating: 1'b0, degenerate: 1'b0};
    if (!cal_done) begin
      need = (cal_target == 0) ? 1 : int'(cal_target);
      for (int k = 0; k < 3; k++) rate_sum[k] += int'(g[k]);
      cal_count++;
      if (cal_count >= need) begin
        for (int k = 0; k < 3; k++) rate_bias[k] = rate_sum[k] / cal_count;
        cal_done = 1'b1;
      end
      r.calibrating = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) g[k] -= rate_bias[k];
    pitch_est = clamp32(pitch_est + round_shift(g[0] * longint'(gyro_gain), 32 - FRAC));
    roll_est = clamp32(roll_est + round_shift(g[1] * longint'(gyro_gain), 32 - FRAC));
    sine = round_shift(g[2] * longint'(yaw_gain), 16);
    pitch_est = clamp32(pitch_est + round_shift(longint'(roll_est) * sine, 24));
    roll_est = clamp32(roll_est - round_shift(longint'(pitch_est) * sine, 24));
    r.degenerate = (s.ax == 0 && s.ay == 0 && s.az == 0);
    pacc = 0;
    racc = 0;
    if (!r.degenerate) begin
      pacc = tilt_angle(s.ay, s.ax, s.az);
      racc = -tilt_angle(s.ax, s.ay, s.az);
    end
    if (seeded) begin
      aw = (accel_weight > 64'd16777216) ? 16777216 : longint'(accel_weight);
      pitch_est = clamp32(pitch_est + round_shift((pacc - pitch_est) * aw, 24));
      roll_est = clamp32(roll_est + round_shift((racc - roll_est) * aw, 24));
    end else begin
      pitch_est = clamp32(pacc);
      roll_est = clamp32(racc);
      seeded = 1'b1;
    end
    sw = (smooth_weight > 64'd65536) ? 65536 : longint'(smooth_weight);
    pitch_out = clamp32(pitch_out + round_shift((longint'(pitch_est) - pitch_out) * sw, 16));
    roll_out = clamp32(roll_out + round_shift((longint'(roll_est) - roll_out) * sw, 16));
    r.pitch = pitch_out;
    r.roll = roll_out;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_GYRO_GAIN:     gyro_gain = val[23:0];
      CFG_YAW_GAIN:      yaw_gain = val[23:0];
      CFG_ACCEL_WEIGHT:  accel_weight = val;
      CFG_SMOOTH_WEIGHT: smooth_weight = val[16:0];
      CFG_CAL_SAMPLES:   cal_target = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (tilt_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_sample(sample_t s, bit typed, tilt_t typed_res);
    tilt_t p;
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
    do @(posedge clk); while (!in_tready);
    p = predict_tilt(s);
    tilt_pending.push_back(typed ? typed_res : p);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: return 16'($signed($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
    if ($urandom_range(0, 15) == 0) begin
      s.ax = 0; s.ay = 0; s.az = 0;
    end
    s.gx = rand_axis(); s.gy = rand_axis(); s.gz = rand_axis();
    return s;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tilt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tilt_pending.size() == 0) begin
        $display("%0t: unexpected beat pitch=%0d roll=%0d", $time,
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
        errors++;
      end else begin
        want = tilt_pending.pop_front();
        if ($signed(out_tdata[31:0]) !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                   $signed(out_tdata[31:0]));
          errors++;
        end
        if ($signed(out_tdata[63:32]) !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                   $signed(out_tdata[63:32]));
          errors++;
        end
        if (out_tuser[0] !== want.calibrating) begin
          $display("%0t: calibrating expected %0b actual %0b", $time, want.calibrating,
                   out_tuser[0]);
          errors++;
        end
        if (out_tuser[1] !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                   out_tuser[1]);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic row_t mk_row(int ax, int ay, int az, int gx, int gy, int gz,
                                  bit typed, bit cut_cal);
    row_t r;
    r.smp = '{ax: 16'(ax), ay: 16'(ay), az: 16'(az), gx: 16'(gx), gy: 16'(gy), gz: 16'(gz)};
    r.typed = typed;
    r.cut_cal = cut_cal;
    r.res = '{pitch: 0, roll: 0, calibrating: 1'b1, degenerate: 1'b0};
    return r;
  endfunction

  initial begin
    row_t    rows[$];
    sample_t s;
    logic [24:0] gg[6], yg[6], aw[6], sw[6];

    gyro_gain = GYRO_GAIN_RST;
    yaw_gain = YAW_GAIN_RST;
    accel_weight = ACCEL_WEIGHT_RST;
    smooth_weight = SMOOTH_WEIGHT_RST;
    cal_target = CAL_SAMPLES_RST;
    for (int k = 0; k < 3; k++) begin
      rate_sum[k] = 0;
      rate_bias[k] = 0;
    end
    cal_count = 0;
    cal_done = 1'b0;
    seeded = 1'b0;
    pitch_est = 0; roll_est = 0; pitch_out = 0; roll_out = 0;

    // calibration beats, then cut calibration short mid-way
    rows.push_back(mk_row(0, 0, 0, 32767, -32768, 5, 1, 0));
    rows.push_back(mk_row(32767, -32768, 0, -32768, 32767, -7, 1, 0));
    rows.push_back(mk_row(-32768, 32767, 32767, 100, -100, 12, 1, 0));
    rows.push_back(mk_row(1, 2, 3, -1, 1, 0, 1, 1));
    // tracking: seed, degenerate, axis extremes, rate extremes
    rows.push_back(mk_row(0, 0, 16384, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(32767, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-32768, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 32767, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, -32768, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(0, 0, -32768, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0));
    rows.push_back(mk_row(32767, 32767, 32767, -32768, -32768, -32768, 0, 0));
    rows.push_back(mk_row(1, -1, 0, 32767, -32768, 32767, 0, 0));
    rows.push_back(mk_row(0, 0, 0, -32768, 32767, -32768, 0, 0));
    rows.push_back(mk_row(-1, -1, -1, 1, -1, 1, 0, 0));
    rows.push_back(mk_row(12000, -8000, 14000, 300, -250, 40, 0, 0));

    gg = '{25'd0, 25'hffffff, 25'd262423, 25'd5000000, 25'hffffff, 25'd1000};
    yg = '{25'hffffff, 25'd0, 25'd1172078, 25'hffffff, 25'd300000, 25'd1};
    aw = '{25'd16777216, 25'd0, 25'h1ffffff, 25'd6711, 25'd100000, 25'd1};
    sw = '{25'd0, 25'd65536, 25'd131071, 25'd6554, 25'd1, 25'd40000};

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cut_cal) begin
        drain();
        write_reg(CFG_CAL_SAMPLES, 25'd1);
      end
      send_sample(rows[i].smp, rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CFG_GYRO_GAIN, gg[ph]);
      write_reg(CFG_YAW_GAIN, yg[ph]);
      write_reg(CFG_ACCEL_WEIGHT, aw[ph]);
      write_reg(CFG_SMOOTH_WEIGHT, sw[ph]);
      write_reg(CFG_CAL_SAMPLES, (ph % 2 == 0) ? 25'd4095 : 25'd0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = rand_sample();
        send_sample(s, 1'b0, '{pitch: 0, roll: 0, calibrating: 1'b0, degenerate: 1'b0});
      end
    end

    drain();
    quiet = 1'b1;
    for (int n = 0; n < QUIET_ITEMS; n++) begin
      s = rand_sample();
      send_sample(s, 1'b0, '{pitch: 0, roll: 0, calibrating: 1'b0, degenerate: 1'b0});
    end

    while (tilt_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ictf_pkg.sv
hdl/ictf_ctrl.sv
hdl/ictf_dp.sv
hdl/imu_complementary_tilt_filter_unit.sv
verif/tb_imu_complementary_tilt_filter_unit.sv
